/* rtl/core/bse_pkg.sv */
package bse_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ChargeW = 38;
  localparam int unsigned MulAW   = 38;
  localparam int unsigned MulBW   = 16;
  localparam int unsigned MulPW   = 54;
  localparam int unsigned DivNW   = 54;
  localparam int unsigned DivDW   = 38;
  localparam int unsigned DivLenW = 6;
  localparam int unsigned MulCntW = 5;

  localparam logic [CfgIdxW-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CUTOFF   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REST     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_JUMP     = 2'd3;

  localparam logic [MulAW-1:0] MS_PER_HOUR = 38'd3600000;
  localparam logic [MulBW-1:0] PCT_TO_MAMS = 16'd36000;
  localparam logic [MulBW-1:0] SOC_SCALE   = 16'd10000;
  localparam logic [DivDW-1:0] BLEND_DIV   = 38'd10;
  localparam logic [ChargeW-1:0] CHARGE_RST = 38'd7920000000;

  // One segment of the voltage curve: percent = base + num / den.
  typedef struct packed {
    logic [6:0]  base;
    logic [13:0] num;
    logic [8:0]  den;
  } seg_t;

  function automatic seg_t curve_seg(input logic [15:0] mv);
    seg_t s;
    s.base = 7'd0;
    s.num  = 14'd0;
    s.den  = 9'd1;
    if (mv <= 16'd6500) begin
      s.base = 7'd0;
    end else if (mv >= 16'd8400) begin
      s.base = 7'd100;
    end else if (mv <= 16'd6800) begin
      s.base = 7'd0;
      s.num  = 14'((mv - 16'd6500) * 16'd20);
      s.den  = 9'd300;
    end else if (mv <= 16'd7200) begin
      s.base = 7'd20;
      s.num  = 14'((mv - 16'd6800) * 16'd20);
      s.den  = 9'd400;
    end else if (mv <= 16'd7600) begin
      s.base = 7'd40;
      s.num  = 14'((mv - 16'd7200) * 16'd25);
      s.den  = 9'd400;
    end else if (mv <= 16'd8000) begin
      s.base = 7'd65;
      s.num  = 14'((mv - 16'd7600) * 16'd25);
      s.den  = 9'd400;
    end else begin
      s.base = 7'd90;
      s.num  = 14'((mv - 16'd8000) * 16'd10);
      s.den  = 9'd400;
    end
    return s;
  endfunction

endpackage

/* rtl/core/bse_mul.sv */
module bse_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bse_pkg::MulAW-1:0]  a_i,
  input  logic [bse_pkg::MulBW-1:0]  b_i,
  output logic                       done_o,
  output logic [bse_pkg::MulPW-1:0]  prod_o
);
  import bse_pkg::*;

  logic               busy_q;
  logic [MulCntW-1:0] cnt_q;
  logic [MulPW-1:0]   a_q;
  logic [MulBW-1:0]   b_q;
  logic [MulPW-1:0]   acc_q;

  // Shift-add, one multiplier bit per cycle, LSB first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= MulCntW'(MulBW);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= MulPW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = acc_q;
endmodule

/* rtl/core/bse_div.sv */
module bse_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bse_pkg::DivNW-1:0]    num_i,
  input  logic [bse_pkg::DivDW-1:0]    den_i,
  input  logic [bse_pkg::DivLenW-1:0]  len_i,
  output logic                         done_o,
  output logic [bse_pkg::DivNW-1:0]    quo_o
);
  import bse_pkg::*;

  logic               busy_q;
  logic [DivLenW-1:0] cnt_q;
  logic [DivNW-1:0]   n_q;
  logic [DivNW-1:0]   q_q;
  logic [DivDW-1:0]   r_q;
  logic [DivDW-1:0]   den_q;
  logic [DivDW:0]     r_sh;
  logic               fits;
  logic [DivDW:0]     r_sub;
  logic [DivLenW-1:0] shamt;

  assign shamt = DivLenW'(DivNW) - len_i;
  assign r_sh  = {r_q, n_q[DivNW-1]};
  assign fits  = r_sh >= {1'b0, den_q};
  assign r_sub = r_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= len_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i << shamt;
      q_q   <= '0;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      n_q <= n_q << 1;
      q_q <= {q_q[DivNW-2:0], fits};
      r_q <= fits ? r_sub[DivDW-1:0] : r_sh[DivDW-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = q_q;
endmodule

/* rtl/core/battery_soc_estimator_core.sv */
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+---------------------------------------
// in       | input     | in_valid_i / in_stall_o  | vbat_mv_i, ibat_ma_i, dt_ms_i
// out      | output    | out_valid_o / out_stall_i| soc_centipercent_o
// cfg      | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One sample at a time: the input stalls until the sequencer is back in idle. A sample
// at rest may add the blend divide, and one below cutoff skips the arithmetic. The work
// runs on the shared bit-serial multiplier and the restoring divider (one bit per
// cycle). Reset returns the sequencer and configuration to their defaults,
// sets the charge to full capacity and clears the previous voltage and seeded flag.
// A finished result waits in the output register; the next sample is taken meanwhile
// and its result holds back until the pending transfer completes.
module battery_soc_estimator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   vbat_mv_i,
  input  logic signed [15:0]            ibat_ma_i,
  input  logic [15:0]                   dt_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [13:0]                   soc_centipercent_o,
  input  logic                          cfg_we_i,
  input  logic [bse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bse_pkg::CfgW-1:0]      cfg_wdata_i
);
  import bse_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHK   = 11'b00000000010,
    S_PCT   = 11'b00000000100,
    S_EST   = 11'b00000001000,
    S_FULL  = 11'b00000010000,
    S_CD    = 11'b00000100000,
    S_BL    = 11'b00001000000,
    S_CLAMP = 11'b00010000000,
    S_SM    = 11'b00100000000,
    S_SD    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  localparam logic [DivLenW-1:0] LEN_PCT = 6'd14;
  localparam logic [DivLenW-1:0] LEN_BL  = 6'd44;
  localparam logic [DivLenW-1:0] LEN_SOC = 6'd54;

  state_e state_q, state_d;

  // configuration
  logic [15:0] cap_q, cutoff_q;
  logic [9:0]  rest_q, jump_q;

  // architectural state
  logic [ChargeW-1:0] charge_q, charge_d;
  logic [15:0]        prev_q, prev_d;
  logic               seeded_q, seeded_d;

  // sample and working registers
  logic [15:0]        v_q;
  logic signed [15:0] cur_q;
  logic [15:0]        dt_q;
  logic [6:0]         base_q, base_d;
  logic [ChargeW-1:0] est_q, est_d, full_q, full_d;
  logic signed [43:0] c_q, c_d;
  logic [13:0]        res_q, res_d;
  logic               out_valid_q;
  logic [13:0]        soc_q;

  // shared units
  logic              mul_start, mul_done, div_start, div_done;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [MulPW-1:0]  mul_prod;
  logic [DivNW-1:0]  div_num, div_quo;
  logic [DivDW-1:0]  div_den;
  logic [DivLenW-1:0] div_len;

  bse_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  bse_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den), .len_i(div_len),
    .done_o(div_done), .quo_o(div_quo)
  );

  seg_t               seg;
  logic [15:0]        cur_mag;
  logic               at_rest;
  logic [15:0]        vdiff;
  logic               jumped;
  logic signed [39:0] c0, c1, moved;
  logic signed [43:0] blend_n;
  logic [6:0]         pct;
  logic               out_free;

  assign seg     = curve_seg(v_q);
  assign cur_mag = cur_q[15] ? (~cur_q + 16'd1) : cur_q;
  assign at_rest = cur_mag < {6'd0, rest_q};
  assign vdiff   = (v_q > prev_q) ? (v_q - prev_q) : (prev_q - v_q);
  assign jumped  = (prev_q != 16'd0) && (vdiff > {6'd0, jump_q});
  assign pct     = base_q + div_quo[6:0];

  // Seed from the voltage estimate while unseeded, then subtract the moved charge (add it for a negative current).
  assign c0      = seeded_q ? $signed({2'b00, charge_q}) : $signed({2'b00, est_q});
  assign moved   = $signed({8'd0, mul_prod[31:0]});
  assign c1      = cur_q[15] ? (c0 + moved) : (c0 - moved);
  assign blend_n = ($signed(44'(c1)) <<< 3) + $signed(44'(c1)) + $signed({6'd0, est_q});

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    charge_d  = charge_q;
    prev_d    = prev_q;
    seeded_d  = seeded_q;
    base_d    = base_q;
    est_d     = est_q;
    full_d    = full_q;
    c_d       = c_q;
    res_d     = res_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_len   = LEN_PCT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (v_q < cutoff_q) begin
          charge_d = '0;
          seeded_d = 1'b0;
          res_d    = '0;
          state_d  = S_OUT;
        end else begin
          base_d    = seg.base;
          div_start = 1'b1;
          div_num   = DivNW'(seg.num);
          div_den   = DivDW'(seg.den);
          div_len   = LEN_PCT;
          state_d   = S_PCT;
        end
      end
      S_PCT: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = MulAW'({16'd0, pct} * {7'd0, cap_q});
          mul_b     = PCT_TO_MAMS;
          state_d   = S_EST;
        end
      end
      S_EST: begin
        if (mul_done) begin
          est_d     = mul_prod[ChargeW-1:0];
          mul_start = 1'b1;
          mul_a     = MS_PER_HOUR;
          mul_b     = cap_q;
          state_d   = S_FULL;
        end
      end
      S_FULL: begin
        if (mul_done) begin
          full_d    = mul_prod[ChargeW-1:0];
          mul_start = 1'b1;
          mul_a     = MulAW'(cur_mag);
          mul_b     = dt_q;
          state_d   = S_CD;
        end
      end
      S_CD: begin
        if (mul_done) begin
          seeded_d = 1'b1;
          prev_d   = v_q;
          if (at_rest) begin
            if (blend_n[43]) begin
              c_d     = '0;
              state_d = S_CLAMP;
            end else begin
              div_start = 1'b1;
              div_num   = DivNW'(blend_n[42:0]);
              div_den   = BLEND_DIV;
              div_len   = LEN_BL;
              state_d   = S_BL;
            end
          end else begin
            c_d     = jumped ? $signed({6'd0, est_q}) : 44'(c1);
            state_d = S_CLAMP;
          end
        end
      end
      S_BL: begin
        if (div_done) begin
          c_d     = $signed({1'b0, div_quo[42:0]});
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (c_q[43]) begin
          charge_d = '0;
        end else if (c_q > $signed({6'd0, full_q})) begin
          charge_d = full_q;
        end else begin
          charge_d = c_q[ChargeW-1:0];
        end
        if (full_q == '0) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          mul_start = 1'b1;
          mul_a     = charge_d;
          mul_b     = SOC_SCALE;
          state_d   = S_SM;
        end
      end
      S_SM: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = DivNW'(mul_prod);
          div_den   = full_q;
          div_len   = LEN_SOC;
          state_d   = S_SD;
        end
      end
      S_SD: begin
        if (div_done) begin
          res_d   = div_quo[13:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= 16'd2200;
      cutoff_q    <= 16'd6500;
      rest_q      <= 10'd5;
      jump_q      <= 10'd50;
      charge_q    <= CHARGE_RST;
      prev_q      <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      charge_q <= charge_d;
      prev_q   <= prev_d;
      seeded_q <= seeded_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY: cap_q    <= cfg_wdata_i;
          REG_CUTOFF:   cutoff_q <= cfg_wdata_i;
          REG_REST:     rest_q   <= cfg_wdata_i[9:0];
          REG_JUMP:     jump_q   <= cfg_wdata_i[9:0];
          default: begin
          end
        endcase
      end
      // Hold the result until the transfer completes.
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      v_q   <= vbat_mv_i;
      cur_q <= ibat_ma_i;
      dt_q  <= dt_ms_i;
    end
    base_q <= base_d;
    est_q  <= est_d;
    full_q <= full_d;
    c_q    <= c_d;
    res_q  <= res_d;
    if (state_q == S_OUT && out_free) begin
      soc_q <= res_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign soc_centipercent_o = soc_q;
endmodule

/* sim/battery_soc_estimator_core_tb.sv */
`timescale 1ns / 1ps

// Tracks configuration and charge state alongside the block and holds the SoC
// values it owes, oldest first.
class soc_scoreboard;
  logic [15:0] capacity_mah;
  logic [15:0] cutoff_mv;
  logic [9:0]  rest_ma;
  logic [9:0]  jump_mv;
  longint      charge;
  logic [15:0] last_mv;
  bit          seeded;
  logic [13:0] soc_q[$];
  int          errors;
  int          n_checked;
  int          n_rest;
  int          n_jump;
  int          n_cutoff;

  function new();
    capacity_mah = 16'd2200;
    cutoff_mv    = 16'd6500;
    rest_ma      = 10'd5;
    jump_mv      = 10'd50;
    charge       = 64'd7920000000;
    last_mv      = 16'd0;
    seeded       = 1'b0;
    errors       = 0;
    n_checked    = 0;
    n_rest       = 0;
    n_jump       = 0;
    n_cutoff     = 0;
  endfunction

  function void set_reg(logic [bse_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      bse_pkg::REG_CAPACITY: capacity_mah = data;
      bse_pkg::REG_CUTOFF:   cutoff_mv = data;
      bse_pkg::REG_REST:     rest_ma = data[9:0];
      bse_pkg::REG_JUMP:     jump_mv = data[9:0];
      default: ;
    endcase
  endfunction

  // Piecewise-linear voltage-to-percent curve, percent truncated.
  function int volt_pct(int mv);
    int pts[6] = '{6500, 6800, 7200, 7600, 8000, 8400};
    int pct[6] = '{0, 20, 40, 65, 90, 100};
    if (mv <= pts[0]) return 0;
    if (mv >= pts[5]) return 100;
    for (int i = 0; i < 5; i++) begin
      if (mv <= pts[i+1])
        return pct[i] + ((mv - pts[i]) * (pct[i+1] - pct[i])) / (pts[i+1] - pts[i]);
    end
    return 0;
  endfunction

  // Advance the charge state for one accepted sample and queue its SoC.
  function void note_sample(logic [15:0] v, logic signed [15:0] cur, logic [15:0] dt);
    longint full;
    longint est;
    int     c;
    int     r;
    int     d;
    full = longint'(capacity_mah) * 64'd3600000;
    if (v < cutoff_mv) begin
      charge = 0;
      seeded = 1'b0;
      n_cutoff++;
      soc_q.push_back(14'd0);
      return;
    end
    est = longint'(volt_pct(int'(v))) * longint'(capacity_mah) * 64'd36000;
    if (!seeded) begin
      charge = est;
      seeded = 1'b1;
    end
    charge = charge - longint'(cur) * longint'(dt);
    c = int'(cur);
    r = int'(rest_ma);
    if (c > -r && c < r) begin
      charge = (9 * charge + est) / 10;
      n_rest++;
    end else if (last_mv != 16'd0) begin
      d = (v > last_mv) ? int'(v) - int'(last_mv) : int'(last_mv) - int'(v);
      if (d > int'(jump_mv)) begin
        charge = est;
        n_jump++;
      end
    end
    last_mv = v;
    if (charge < 0) charge = 0;
    if (charge > full) charge = full;
    if (full == 0) soc_q.push_back(14'd0);
    else soc_q.push_back(14'((charge * 10000) / full));
  endfunction

  function void check_soc(logic [13:0] got);
    logic [13:0] want;
    if (soc_q.size() == 0) begin
      $display("%0t: unexpected soc_centipercent %0d", $time, got);
      errors++;
      return;
    end
    want = soc_q.pop_front();
    n_checked++;
    if (got !== want) begin
      $display("%0t: soc_centipercent expected %0d actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module battery_soc_estimator_core_tb;
  import bse_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [15:0]         vbat_mv = '0;
  logic signed [15:0]  ibat_ma = '0;
  logic [15:0]         dt_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [13:0]         soc;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = REG_CAPACITY;
  logic [CfgW-1:0]     cfg_wdata = '0;

  soc_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int n_sent = 0;
  int quiet_cycles = 0;
  int track_mv = 7400;

  always #10 clk_i = ~clk_i;

  battery_soc_estimator_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .vbat_mv_i          (vbat_mv),
    .ibat_ma_i          (ibat_ma),
    .dt_ms_i            (dt_ms),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .soc_centipercent_o (soc),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  // Receiver: check each output transfer, then pick the stall for the next cycle.
  // A long hold-off, once requested, is counted down here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_soc(soc);
    if (hold_req) begin
      hold_left = 600;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: give up after a long run of cycles with no transfer at all.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
        $display("%0t: watchdog expired, %0d results still owed", $time, sb.soc_q.size());
        $display("battery_soc_estimator_core_tb: errors");
        $finish;
      end
    end
  end

  // Offer one sample and hold it until the transfer; then maybe go idle a while.
  task automatic send_sample(logic [15:0] v, logic signed [15:0] c, logic [15:0] dt);
    in_valid <= 1'b1;
    vbat_mv  <= v;
    ibat_ma  <= c;
    dt_ms    <= dt;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_sample(v, c, dt);
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.soc_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // Only called with the block drained.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a slowly drifting voltage with mixed currents; some jumps and raw noise.
  task automatic make_sample(output logic [15:0] v, output logic signed [15:0] c,
                             output logic [15:0] dt);
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 8) begin
      v  = 16'($urandom_range(40000));
      c  = 16'($urandom);
      dt = 16'($urandom);
      return;
    end
    if (r < 16) track_mv = $urandom_range(6000, 9000);
    else track_mv = track_mv + $urandom_range(60) - 30;
    if (track_mv < 6300) track_mv = 6300;
    if (track_mv > 8600) track_mv = 8600;
    v = 16'(track_mv);
    k = $urandom_range(9);
    if (k < 3) c = 16'($urandom_range(12) - 6);
    else if (k < 8) c = 16'($urandom_range(6000) - 3000);
    else c = 16'($urandom);
    dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
  endtask

  initial begin
    logic [15:0]        v;
    logic signed [15:0] c;
    logic [15:0]        dt;
    logic [15:0]        cap_set[6]  = '{16'd1, 16'd65535, 16'd0, 16'd2200, 16'd500, 16'd3000};
    logic [15:0]        cut_set[6]  = '{16'd0, 16'd40000, 16'd6500, 16'd65535, 16'd7000, 16'd6000};
    logic [15:0]        rest_set[6] = '{16'd0, 16'd1023, 16'd1000, 16'd5, 16'd100, 16'd1};
    logic [15:0]        jump_set[6] = '{16'd1023, 16'd0, 16'd1000, 16'd50, 16'd10, 16'd200};
    int                 idle_s[4]   = '{0, 57, 0, 24};
    int                 stall_s[4]  = '{0, 0, 57, 24};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: cutoff, seeding, curve knees, field extremes, rest edges, jumps.
    send_sample(16'd0, 16'sd0, 16'd0);
    send_sample(16'd6499, 16'sd100, 16'd10);
    send_sample(16'd6500, 16'sd0, 16'd0);
    send_sample(16'd6800, 16'sd4, 16'd1000);
    send_sample(16'd7200, -16'sd4, 16'd1000);
    send_sample(16'd7600, 16'sd5, 16'd1000);
    send_sample(16'd8000, -16'sd5, 16'd1000);
    send_sample(16'd8400, 16'sd0, 16'd65535);
    send_sample(16'd40000, 16'sh8000, 16'd65535);
    send_sample(16'd40000, 16'sh7fff, 16'd65535);
    send_sample(16'd7333, 16'sd200, 16'd500);
    send_sample(16'd7383, 16'sd200, 16'd500);
    send_sample(16'd7434, 16'sd200, 16'd500);
    send_sample(16'd7383, -16'sd200, 16'd500);
    send_sample(16'd6650, 16'sd1, 16'd0);
    send_sample(16'd7999, 16'sh7fff, 16'd65535);
    send_sample(16'd8001, 16'sh8000, 16'd65535);
    send_sample(16'd1000, 16'sd50, 16'd50);
    send_sample(16'd8200, 16'sd50, 16'd50);
    send_sample(16'd6501, -16'sd1, 16'd1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CAPACITY, cap_set[p]);
      write_reg(REG_CUTOFF, cut_set[p]);
      write_reg(REG_REST, rest_set[p]);
      write_reg(REG_JUMP, jump_set[p]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct  = idle_s[m];
        recv_stall_pct = stall_s[m];
        for (int i = 0; i < 58; i++) begin
          make_sample(v, c, dt);
          send_sample(v, c, dt);
          // Backpressure: starve the output while samples keep coming.
          if (p == 1 && m == 0 && i == 10) hold_req = 1'b1;
          // Let everything owed come back before resuming.
          if (p == 3 && m == 1 && i == 20) begin
            in_valid <= 1'b0;
            while (sb.soc_q.size() != 0) @(posedge clk_i);
          end
        end
      end
      drain();
    end

    $display("%0d samples sent, %0d SoC values checked", n_sent, sb.n_checked);
    $display("%0d below cutoff, %0d rest blends, %0d jump recalibrations, 6 settings",
             sb.n_cutoff, sb.n_rest, sb.n_jump);
    if (sb.errors == 0 && sb.soc_q.size() == 0) begin
      $display("battery_soc_estimator_core_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.soc_q.size());
      $display("battery_soc_estimator_core_tb: errors");
    end
    $finish;
  end

endmodule
